// ----- rtl/polyphase_sinc_resampler_defines.svh -----
// Assertion macros for the polyphase resampler.
// Included by the top level; no other dependencies.
`ifndef POLYPHASE_SINC_RESAMPLER_DEFINES_SVH
`define POLYPHASE_SINC_RESAMPLER_DEFINES_SVH
`define PSR_ASSERT_IMPL(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define PSR_ASSERT_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ----- rtl/psr_pkg.sv -----
// Shared constants and types for the polyphase resampler.
// No dependencies.
`timescale 1ns / 1ps
package psr_pkg;
  localparam int PHASES_DEF = 4096;
  localparam int MAX_TAPS_DEF = 64;
  localparam int HISTORY_DEPTH_DEF = 128;
  localparam int CHANNELS_DEF = 2;
  localparam int MAX_OUT = 4;
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_PUSH = 1'b1;
  localparam logic [0:0] REG_STEP = 1'b0;
  localparam logic [0:0] REG_TAPS = 1'b1;
  localparam logic [23:0] STEP_RESET = 24'd65536;
  localparam logic [6:0] TAPS_RESET = 7'd64;

  typedef struct packed {
    logic clear;
    logic en;
  } mac_ctl_t;

  function automatic logic signed [15:0] round_sat(input logic signed [47:0] acc);
    logic signed [47:0] r;
    r = (acc + 48'sd65536) >>> 17;
    if (r > 48'sd32767) return 16'sh7fff;
    if (r < -48'sd32768) return 16'sh8000;
    return r[15:0];
  endfunction
endpackage

// ----- rtl/psr_mac.sv -----
// Shared multiply-accumulate unit, one sample by one coefficient per cycle while enabled.
// Depends on psr_pkg.
`timescale 1ns / 1ps
module psr_mac (
  input  logic                 clk,
  input  psr_pkg::mac_ctl_t    ctl,
  input  logic signed [15:0]   smp,
  input  logic signed [17:0]   coef,
  output logic signed [47:0]   acc
);
  logic signed [33:0] prod;
  logic prod_en;
  always_ff @(posedge clk) begin
    prod <= smp * coef;
    prod_en <= ctl.en;
    if (ctl.clear) begin
      acc <= '0;
    end else if (prod_en) begin
      acc <= acc + {{14{prod[33]}}, prod};
    end
  end
endmodule

// ----- rtl/polyphase_sinc_resampler.sv -----
// channel  dir  handshake            payload, low bits first
// s_axis   in   tvalid/tready        tuser: command; tdata: row,tap,value,left,right
// m_axis   out  tvalid/tready/tlast  tdata: out_left,out_right; tlast: last_of_run
// cfg      in   cfg_we               cfg_index picks step_ratio / tap_count
// A load leaves tready high. A push holds tready low from CHECK to DONE; CHECK repeats when the
// lag is pulled back to the history. Each output takes CHECK, then a MAC pass over the taps
// and a drain per channel through one multiplier, then OUT.
// At most four outputs per push.
// rst is synchronous; a clearing pass over the history follows with tready low.
// A stalled result waits in the output register; the next one waits in S_OUT.
`timescale 1ns / 1ps
`include "polyphase_sinc_resampler_defines.svh"
module polyphase_sinc_resampler #(
  parameter int PHASES = psr_pkg::PHASES_DEF,
  parameter int MAX_TAPS = psr_pkg::MAX_TAPS_DEF,
  parameter int HISTORY_DEPTH = psr_pkg::HISTORY_DEPTH_DEF,
  parameter int CHANNELS = psr_pkg::CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // command[0]
  input  logic        s_axis_tuser,
  // coeff_row[10:0], coeff_tap[16:11], coeff_value[34:17],
  // sample_left[50:35], sample_right[66:51], zero fill
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_left[15:0], out_right[31:16]
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [23:0] cfg_data
);
  localparam int ROWS = PHASES / 2;
  localparam int RW = $clog2(ROWS);
  localparam int TW = $clog2(MAX_TAPS);
  localparam int HW = $clog2(HISTORY_DEPTH);
  localparam int PW = $clog2(PHASES);
  localparam logic [8:0] MAXT4 = 9'((MAX_TAPS / 4) * 4);
  localparam logic signed [32:0] HSPAN = 33'(HISTORY_DEPTH * 65536);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_CHECK, S_MAC, S_DRAIN, S_OUT, S_DONE}
    state_t;
  state_t state;

  logic [23:0] step_ratio;
  logic [6:0] tap_count;
  logic signed [17:0] cmem [ROWS << TW];
  logic [31:0] hmem [HISTORY_DEPTH];
  logic [HW-1:0] head, hptr;
  logic signed [31:0] e;
  logic [2:0] nout;
  logic [8:0] taps, idx;
  logic ch;
  logic upper;
  logic [RW-1:0] row;
  logic [HW:0] clr;
  logic [31:0] hword;
  logic signed [17:0] cword;
  logic [2:0] drain;
  logic signed [15:0] res_l;
  logic signed [47:0] acc;
  psr_pkg::mac_ctl_t ctl;

  logic cmd;
  logic [10:0] in_row;
  logic [5:0] in_tap;
  logic [31:0] word;
  assign cmd = s_axis_tuser;
  assign in_row = s_axis_tdata[10:0];
  assign in_tap = s_axis_tdata[16:11];
  assign word = {(CHANNELS == 2) ? s_axis_tdata[66:51] : 16'd0, s_axis_tdata[50:35]};

  logic [8:0] taps_c;
  always_comb begin
    taps_c = {2'b0, tap_count[6:2], 2'b00};
    if (taps_c < 9'd4) taps_c = 9'd4;
    if (taps_c > MAXT4) taps_c = MAXT4;
  end

  logic signed [32:0] thr;
  assign thr = (33'sd1 - $signed({24'd0, taps})) <<< 16;
  logic signed [32:0] e33;
  assign e33 = 33'(e);
  logic signed [32:0] e_adv;
  assign e_adv = e33 + $signed({9'd0, step_ratio});

  logic [PW:0] tph;
  assign tph = (PW + 1)'((({16'd0, e[15:0]} * 32'(PHASES)) + 32'd32768) >> 16);
  logic [PW-1:0] tmod;
  assign tmod = tph[PW-1:0];

  logic clamp, due, start_out, start_right;
  assign clamp = e33 < thr - HSPAN;
  assign due = (e33 < thr) && (nout != 3'(psr_pkg::MAX_OUT));
  assign start_out = (state == S_CHECK) && !clamp && due;
  assign start_right = (state == S_DRAIN) && (drain == 3'd3) && !ch && (CHANNELS == 2);

  assign s_axis_tready = (state == S_IDLE);
  wire in_acc = s_axis_tvalid && s_axis_tready;

  logic [TW-1:0] ci;
  assign ci = upper ? TW'(taps - 9'd1 - idx) : TW'(idx);

  psr_mac u_mac (.clk(clk), .ctl(ctl),
    .smp(ch ? hword[31:16] : hword[15:0]), .coef(cword), .acc(acc));

  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      hmem[clr[HW-1:0]] <= '0;
    end else if (in_acc && cmd == psr_pkg::CMD_PUSH) begin
      hmem[head] <= word;
    end
    if (in_acc && cmd == psr_pkg::CMD_LOAD && 32'(in_row) < 32'(ROWS)
        && 32'(in_tap) < 32'(MAX_TAPS))
      cmem[{RW'(in_row), TW'(in_tap)}] <= s_axis_tdata[34:17];
    hword <= hmem[hptr + HW'(idx)];
    cword <= cmem[{row, ci}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR; clr <= '0; step_ratio <= psr_pkg::STEP_RESET;
      tap_count <= psr_pkg::TAPS_RESET; head <= '0; e <= '0;
      m_axis_tvalid <= 1'b0; m_axis_tlast <= 1'b0;
      ctl <= '0;
    end else begin
      ctl.en <= (state == S_MAC);
      ctl.clear <= start_out || start_right;
      if (cfg_we) begin
        if (cfg_index == psr_pkg::REG_STEP) step_ratio <= cfg_data;
        else tap_count <= cfg_data[6:0];
      end
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == (HW + 1)'(HISTORY_DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: if (in_acc && cmd == psr_pkg::CMD_PUSH) begin
          head <= head + 1'b1;
          taps <= taps_c;
          nout <= '0;
          e <= e - 32'sd65536;
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (clamp) begin
            e <= 32'(thr - 33'sd65536);
          end else if (due) begin
            hptr <= HW'(head + HW'(e[31:16]));
            upper <= tmod >= PW'(ROWS);
            row <= (tmod >= PW'(ROWS)) ? RW'(PW'(PHASES - 1) - tmod) : RW'(tmod);
            idx <= '0; ch <= 1'b0;
            state <= S_MAC;
          end else begin
            if (e33 < thr) e <= 32'(thr) + {16'd0, e[15:0]};
            state <= S_DONE;
          end
        end
        S_MAC: begin
          idx <= idx + 1'b1;
          if (idx == taps - 9'd1) begin drain <= '0; state <= S_DRAIN; end
        end
        S_DRAIN: begin
          drain <= drain + 1'b1;
          if (drain == 3'd3) begin
            if (!ch) begin
              res_l <= psr_pkg::round_sat(acc);
              ch <= 1'b1; idx <= '0;
              state <= (CHANNELS == 2) ? S_MAC : S_OUT;
            end else state <= S_OUT;
          end
        end
        S_OUT: if (!m_axis_tvalid) begin
          m_axis_tvalid <= 1'b1;
          m_axis_tdata <= {(CHANNELS == 2) ? psr_pkg::round_sat(acc) : 16'sd0, res_l};
          e <= e_adv[31:0];
          nout <= nout + 1'b1;
          m_axis_tlast <= (nout == 3'(psr_pkg::MAX_OUT - 1)) || !(e_adv < thr);
          state <= S_CHECK;
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  `PSR_ASSERT_NEXT(a_in_busy, clk, rst, in_acc && cmd == psr_pkg::CMD_PUSH, !s_axis_tready)
  `PSR_ASSERT_IMPL(a_out_idle, clk, rst, state == S_MAC, !s_axis_tready)
  `PSR_ASSERT_IMPL(a_cnt, clk, rst, state == S_OUT, nout < 3'd4)
endmodule
